// ===== rtl/core/html_entity_stream_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// html entity stream decoder assertion macros
// concurrent checks that compile away when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_STREAM_DECODER_TOP_DEFINES_SVH
`define HTML_ENTITY_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define HED_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
`define HED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next cycle");
`define HED_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed: invariant");
`else
`define HED_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define HED_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define HED_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif

`endif

// ===== rtl/core/hed_pkg.sv =====
// ----------------------------------------------------------------------------
// hed_pkg
// shared types, character codes and the entity table of the decoder
// ----------------------------------------------------------------------------
package hed_pkg;

	localparam int HOLD_DEPTH = 6;
	localparam int BURST_LEN  = HOLD_DEPTH + 1;
	localparam int NUM_ENT    = 6;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cnt_t;

	localparam cnt_t HOLD_CNT = cnt_t'(HOLD_DEPTH);

	localparam byte_t CH_AMP  = 8'h26;
	localparam byte_t CH_SEMI = 8'h3B;

	typedef logic [HOLD_DEPTH-1:0][7:0] ent_body_t;

	// entity text without the closing semicolon, first character in byte 0
	localparam ent_body_t ENT_BODY [NUM_ENT] = '{
		{8'h00, "t", "o", "u", "q", "&"},
		{8'h00, "s", "o", "p", "a", "&"},
		{8'h00, 8'h00, "p", "m", "a", "&"},
		{8'h00, 8'h00, 8'h00, "t", "g", "&"},
		{8'h00, 8'h00, 8'h00, "t", "l", "&"},
		{"l", "s", "a", "r", "f", "&"}
	};

	localparam cnt_t ENT_LEN [NUM_ENT] = '{3'd5, 3'd5, 3'd4, 3'd3, 3'd3, 3'd6};

	localparam byte_t ENT_REPL [NUM_ENT] = '{8'h22, 8'h27, 8'h26, 8'h3E, 8'h3C, 8'h2F};

	// up to seven result bytes produced by one input byte, in order from byte 0
	typedef struct packed {
		logic [BURST_LEN-1:0][7:0] bytes;
		cnt_t                      count;
		logic                      last;
	} burst_t;

endpackage

// ===== rtl/core/hed_in_if.sv =====
// ----------------------------------------------------------------------------
// hed_in_if
// input byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface hed_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/hed_out_if.sv =====
// ----------------------------------------------------------------------------
// hed_out_if
// decoded byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface hed_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== rtl/core/hed_core.sv =====
// ----------------------------------------------------------------------------
// hed_core
// input register, pending candidate store and entity match, builds one burst
// ----------------------------------------------------------------------------
`include "html_entity_stream_decoder_top_defines.svh"

module hed_core (
	input  logic            clk,
	input  logic            arst_n,
	hed_in_if.sink          in_ch,
	output hed_pkg::burst_t burst,
	output logic            burst_valid,
	input  logic            load_ok
);
	import hed_pkg::*;

	logic                       valid_s1;
	byte_t                      byte_s1;
	logic                       last_s1;
	cnt_t                       cnt_q;
	logic [HOLD_DEPTH-1:0][7:0] pend_q;

	logic [NUM_ENT-1:0] hit;
	logic               match;
	byte_t              repl;
	logic               is_semi;
	logic               is_amp;
	cnt_t               flush_cnt;
	logic               has_extra;
	byte_t              extra;
	cnt_t               cnt_nxt;
	logic               wr_first;
	logic               wr_app;
	logic               advance;

	// entity compare against the held candidate
	always_comb begin
		hit  = '0;
		repl = '0;
		for (int e = 0; e < NUM_ENT; e++) begin
			hit[e] = (cnt_q == ENT_LEN[e]);
			for (int j = 0; j < HOLD_DEPTH; j++) begin
				if (cnt_t'(j) < ENT_LEN[e] && pend_q[j] != ENT_BODY[e][j])
					hit[e] = 1'b0;
			end
			if (hit[e])
				repl = ENT_REPL[e];
		end
		match = |hit;
	end

	// a burst is the flushed candidate prefix followed by at most one extra byte
	always_comb begin
		is_semi   = (byte_s1 == CH_SEMI);
		is_amp    = (byte_s1 == CH_AMP);
		flush_cnt = '0;
		has_extra = 1'b0;
		extra     = byte_s1;
		cnt_nxt   = cnt_q;
		wr_first  = 1'b0;
		wr_app    = 1'b0;
		if (cnt_q != '0) begin
			if (is_semi) begin
				cnt_nxt   = '0;
				has_extra = 1'b1;
				if (match)
					extra = repl;
				else
					flush_cnt = cnt_q;
			end else if (is_amp) begin
				flush_cnt = cnt_q;
				cnt_nxt   = 3'd1;
				wr_first  = 1'b1;
			end else if (cnt_q < HOLD_CNT) begin
				cnt_nxt = cnt_q + 3'd1;
				wr_app  = 1'b1;
			end else begin
				flush_cnt = cnt_q;
				has_extra = 1'b1;
				cnt_nxt   = '0;
			end
		end else if (is_amp) begin
			cnt_nxt  = 3'd1;
			wr_first = 1'b1;
		end else begin
			has_extra = 1'b1;
		end
		// end of text: whatever would stay held goes out behind the old prefix
		if (last_s1 && cnt_nxt != '0) begin
			flush_cnt = cnt_q;
			has_extra = 1'b1;
			cnt_nxt   = '0;
		end
	end

	always_comb begin
		for (int i = 0; i < BURST_LEN; i++)
			burst.bytes[i] = extra;
		for (int i = 0; i < HOLD_DEPTH; i++) begin
			if (cnt_t'(i) < flush_cnt)
				burst.bytes[i] = pend_q[i];
		end
		burst.count = flush_cnt + cnt_t'(has_extra);
		burst.last  = last_s1;
	end

	assign burst_valid = valid_s1 && burst.count != '0;
	assign advance     = valid_s1 && (burst.count == '0 || load_ok);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.in_byte;
			last_s1 <= in_ch.in_last;
		end
		if (advance && wr_first)
			pend_q[0] <= byte_s1;
		else if (advance && wr_app)
			pend_q[cnt_q] <= byte_s1;
	end

	`HED_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= HOLD_CNT)
	`HED_ASSERT_NEXT(a_last_empties, clk, arst_n, advance && last_s1, cnt_q == '0)

endmodule

// ===== rtl/core/hed_outbuf.sv =====
// ----------------------------------------------------------------------------
// hed_outbuf
// result register holding one burst, shifted out one byte per transaction
// ----------------------------------------------------------------------------
`include "html_entity_stream_decoder_top_defines.svh"

module hed_outbuf (
	input  logic            clk,
	input  logic            arst_n,
	input  hed_pkg::burst_t burst,
	input  logic            burst_valid,
	output logic            load_ok,
	hed_out_if.source       out_ch
);
	import hed_pkg::*;

	logic [BURST_LEN-1:0][7:0] buf_q;
	cnt_t                      rem_q;
	logic                      last_q;
	logic                      pop;
	logic                      load;

	assign pop     = out_ch.valid && out_ch.ready;
	// the next burst may enter as the final byte of the current one leaves
	assign load_ok = (rem_q == '0) || (rem_q == 3'd1 && out_ch.ready);
	assign load    = burst_valid && load_ok;

	assign out_ch.valid    = (rem_q != '0);
	assign out_ch.out_byte = buf_q[0];
	assign out_ch.out_last = last_q && rem_q == 3'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= burst.count;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= burst.bytes;
			last_q <= burst.last;
		end else if (pop) begin
			buf_q <= buf_q >> 8;
		end
	end

	`HED_ASSERT_NEXT(a_load_count, clk, arst_n, load, rem_q == $past(burst.count))
	`HED_ASSERT_NEXT(a_pop_count, clk, arst_n, pop && !load, rem_q == $past(rem_q) - 3'd1)

endmodule

// ===== rtl/core/html_entity_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// html_entity_stream_decoder_top
// path: input register, then result register, which drives the output
// throughput: one byte per cycle while out_ch is ready and each byte yields at most one result;
//   a longer burst holds the result register until it drains, and the next byte waits
// reset: arst_n clears the held count, stage valid and result count
// ----------------------------------------------------------------------------
module html_entity_stream_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	hed_in_if.sink    in_ch,
	hed_out_if.source out_ch
);
	import hed_pkg::*;

	burst_t burst;
	logic   burst_valid;
	logic   load_ok;

	hed_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.burst       (burst),
		.burst_valid (burst_valid),
		.load_ok     (load_ok)
	);

	hed_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.burst       (burst),
		.burst_valid (burst_valid),
		.load_ok     (load_ok),
		.out_ch      (out_ch)
	);

endmodule
